// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the slip friction model.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/msfm_pkg.sv -----
// Types and constants of the slip friction model.
// Depends on nothing.
package msfm_pkg;

    typedef enum logic [1:0] {
        ACT_SAMPLE    = 2'd0,
        ACT_THRESHOLD = 2'd1,
        ACT_IN_TAP    = 2'd2,
        ACT_OUT_TAP   = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         channel;
        logic [3:0]         coef_index;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_channel;
        logic signed [31:0] model_output;
        logic               saturated;
    } out_item_t;

    typedef enum logic [1:0] {
        MAC_NONE = 2'd0,
        MAC_IN   = 2'd1,
        MAC_DEF  = 2'd2
    } mac_src_t;

    typedef struct packed {
        logic     start;
        logic     slip_phase;
        logic     mac_phase;
        mac_src_t src;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic slip_last;
        logic mac_last;
    } dp_stat_t;

endpackage

// ----- rtl/msfm_ctrl.sv -----
// Sequencer of the slip friction model: slip update, MAC walk, result.
// Depends on msfm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module msfm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              out_busy,
    input  msfm_pkg::dp_stat_t stat,
    output msfm_pkg::dp_cmd_t cmd,
    output logic              idle,
    output logic              busy_done
);
    import msfm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SLIP = 4'b0010,
        S_MAC  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = MAC_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SLIP;
                end
            end
            S_SLIP:
            begin
                cmd.slip_phase = 1'b1;
                if (stat.slip_last)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac_phase = 1'b1;
                if (stat.mac_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == S_IDLE);
    assign busy_done = (state_reg == S_DONE) && !out_busy;

    `ASSERT_IMPLIES(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `ASSERT_NEXT(a_go, clk, rst_n, idle && go, state_reg == S_SLIP)
    `ASSERT_NEXT(a_done, clk, rst_n, busy_done, idle)
endmodule

// ----- rtl/msfm_datapath.sv -----
// Datapath of the slip friction model: coefficient and history memories,
// slip operator update and a shared multiply-accumulate.
// Depends on msfm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module msfm_datapath #(
    parameter int CHANNELS       = 6,
    parameter int SLIP_OPERATORS = 4,
    parameter int OUTPUT_ORDER   = 3,
    parameter int INPUT_ORDER    = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  msfm_pkg::in_item_t  item,
    input  logic                item_load,
    input  msfm_pkg::dp_cmd_t   cmd,
    output msfm_pkg::dp_stat_t  stat,
    output msfm_pkg::out_item_t result
);
    import msfm_pkg::*;

    localparam int DEF_LEN = SLIP_OPERATORS * (OUTPUT_ORDER + 1);
    localparam int SMP_LEN = INPUT_ORDER + 1;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OP_W    = (SLIP_OPERATORS > 1) ? $clog2(SLIP_OPERATORS) : 1;
    localparam int DEF_W   = (DEF_LEN > 1) ? $clog2(DEF_LEN) : 1;
    localparam int SMP_W   = (SMP_LEN > 1) ? $clog2(SMP_LEN) : 1;
    localparam int CNT_W   = $clog2(DEF_LEN + SMP_LEN + 3) + 1;
    localparam int TOT     = SMP_LEN + DEF_LEN;

    // Histories are circular: a per-channel head pointer marks the newest
    // entry, so aging a history is a pointer step, not a copy.
    logic signed [31:0] thr_mem  [CHANNELS*SLIP_OPERATORS];
    logic signed [31:0] itap_mem [CHANNELS*SMP_LEN];
    logic signed [31:0] otap_mem [CHANNELS*DEF_LEN];
    logic signed [31:0] def_mem  [CHANNELS*DEF_LEN];
    logic signed [31:0] smp_mem  [CHANNELS*SMP_LEN];
    logic [CHANNELS-1:0]         def_vld_reg [DEF_LEN];
    logic [CHANNELS-1:0]         smp_vld_reg [SMP_LEN];

    logic [$clog2(OUTPUT_ORDER+2)-1:0] dhead_reg [CHANNELS];
    logic [$clog2(OUTPUT_ORDER+2)-1:0] dhead_next;
    logic [SMP_W-1:0] shead_reg [CHANNELS];

    in_item_t               cur_reg;
    logic [CH_W-1:0]        ch;
    logic [CH_W-1:0]        ich;
    logic [CNT_W-1:0]       cnt_reg;
    logic signed [63:0]     acc_reg;
    logic signed [31:0]     ra_reg, rb_reg;
    logic                   rvld_reg, rdef_reg;
    logic signed [63:0]     prod_reg;
    logic                   pvld_reg;
    logic signed [31:0]     thr_q, dold_q;
    logic [OP_W-1:0]        op_reg;
    logic [$clog2(OUTPUT_ORDER+2)-1:0] mrow_reg;
    logic [OP_W-1:0]        mcol_reg;
    out_item_t              result_reg;

    assign ch  = cur_reg.channel[CH_W-1:0];
    assign ich = item.channel[CH_W-1:0];

    // Ring slot of delay k for operator j: slot row = (head + k) mod depth.
    function automatic logic [$clog2(OUTPUT_ORDER+2)-1:0] drow(
        input logic [$clog2(OUTPUT_ORDER+2)-1:0] head, input int k);
        logic [$clog2(OUTPUT_ORDER+2):0] s;
        s = {1'b0, head} + k[$clog2(OUTPUT_ORDER+2):0];
        if (s >= (OUTPUT_ORDER + 1))
        begin
            s = s - ($clog2(OUTPUT_ORDER+2)+1)'(OUTPUT_ORDER + 1);
        end
        return s[$clog2(OUTPUT_ORDER+2)-1:0];
    endfunction

    function automatic logic [SMP_W-1:0] srow(input logic [SMP_W-1:0] head,
                                              input int k);
        logic [SMP_W:0] s;
        s = {1'b0, head} + k[SMP_W:0];
        if (s >= SMP_LEN)
        begin
            s = s - SMP_LEN[SMP_W:0];
        end
        return s[SMP_W-1:0];
    endfunction

    assign dhead_next = (dhead_reg[ch] == 0) ? OUTPUT_ORDER[$bits(dhead_next)-1:0]
                                             : dhead_reg[ch] - 1'b1;

    // Coefficient writes happen on acceptance; samples are latched.
    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            cur_reg <= item;
            if (item.action == ACT_THRESHOLD && item.coef_index < SLIP_OPERATORS)
            begin
                thr_mem[item.channel[CH_W-1:0]*SLIP_OPERATORS + item.coef_index] <=
                    item.value;
            end
            if (item.action == ACT_IN_TAP && item.coef_index < SMP_LEN)
            begin
                itap_mem[item.channel[CH_W-1:0]*SMP_LEN + item.coef_index] <= item.value;
            end
            if (item.action == ACT_OUT_TAP && item.coef_index < DEF_LEN)
            begin
                otap_mem[item.channel[CH_W-1:0]*DEF_LEN + item.coef_index] <= item.value;
            end
        end
    end

    // Slip phase: an even counter step reads the threshold and newest deformation
    // of operator cnt/2; the odd step writes the clipped value into the new head row.
    logic signed [33:0] h, mag, m;
    logic signed [33:0] lim;
    logic signed [33:0] d;
    logic signed [31:0] dsat;
    always_comb
    begin
        h   = 34'(cur_reg.value) + 34'(def_vld_reg[32'(dhead_reg[ch])*SLIP_OPERATORS
                                                    + 32'(op_reg)][ch] ? dold_q : 32'sd0);
        mag = (h < 0) ? -h : h;
        lim = 34'(thr_q);
        m   = (mag < lim) ? mag : lim;
        d   = (h > 0) ? m : ((h < 0) ? -m : 34'sd0);
        if (d > 34'sd2147483647)
        begin
            dsat = 32'sh7fffffff;
        end
        else if (d < -34'sd2147483648)
        begin
            dsat = 32'sh80000000;
        end
        else
        begin
            dsat = d[31:0];
        end
    end

    // MAC walk: step t < TOT issues read t; products follow through the operand registers and the product register.
    logic [DEF_W-1:0] di;
    logic [SMP_W-1:0] si;
    logic signed [63:0] pq;
    always_comb
    begin
        di = '0;
        si = '0;
        if (cnt_reg < SMP_LEN)
        begin
            si = cnt_reg[SMP_W-1:0];
        end
        else
        begin
            di = DEF_W'(cnt_reg - SMP_LEN[CNT_W-1:0]);
        end
        pq = prod_reg >>> 16;
    end

    always_ff @(posedge clk)
    begin
        thr_q  <= thr_mem[ch*SLIP_OPERATORS + cnt_reg[CNT_W-1:1]];
        dold_q <= def_mem[ch*DEF_LEN + 32'(dhead_reg[ch])*SLIP_OPERATORS
                          + 32'(cnt_reg[CNT_W-1:1])];
        if (cmd.slip_phase && cnt_reg[0])
        begin
            def_mem[ch*DEF_LEN + 32'(dhead_next)*SLIP_OPERATORS + 32'(op_reg)] <= dsat;
        end
        if (cmd.start)
        begin
            smp_mem[ich*SMP_LEN + 32'(srow(shead_reg[ich], SMP_LEN - 1))] <= item.value;
        end
        if (cmd.mac_phase && cnt_reg < TOT)
        begin
            if (cnt_reg < SMP_LEN)
            begin
                ra_reg <= itap_mem[ch*SMP_LEN + si];
                rb_reg <= smp_mem[ch*SMP_LEN + srow(shead_reg[ch], int'(si))];
            end
            else
            begin
                ra_reg <= otap_mem[ch*DEF_LEN + di];
                rb_reg <= def_mem[ch*DEF_LEN
                    + 32'(drow(dhead_reg[ch], int'(mrow_reg)))*SLIP_OPERATORS
                    + 32'(mcol_reg)];
            end
            rdef_reg <= (cnt_reg >= SMP_LEN)
                ? def_vld_reg[32'(drow(dhead_reg[ch], int'(mrow_reg)))
                              *SLIP_OPERATORS + 32'(mcol_reg)][ch]
                : smp_vld_reg[srow(shead_reg[ch], int'(si))][ch];
        end
        prod_reg <= (rdef_reg ? 64'(ra_reg) * 64'(rb_reg) : 64'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            op_reg   <= '0;
            mrow_reg <= '0;
            mcol_reg <= '0;
            rvld_reg <= 1'b0;
            pvld_reg <= 1'b0;
            acc_reg  <= '0;
            for (int r = 0; r < CHANNELS; r++)
            begin
                dhead_reg[r] <= '0;
                shead_reg[r] <= '0;
            end
            for (int e = 0; e < DEF_LEN; e++)
            begin
                def_vld_reg[e] <= '0;
            end
            for (int e = 0; e < SMP_LEN; e++)
            begin
                smp_vld_reg[e] <= '0;
            end
        end
        else
        begin
            rvld_reg <= cmd.mac_phase && (cnt_reg < TOT);
            pvld_reg <= rvld_reg;
            if (cmd.start)
            begin
                cnt_reg  <= '0;
                op_reg   <= '0;
                mrow_reg <= '0;
                mcol_reg <= '0;
                acc_reg  <= '0;
                shead_reg[ich] <= srow(shead_reg[ich], SMP_LEN - 1);
                smp_vld_reg[srow(shead_reg[ich], SMP_LEN - 1)][ich] <= 1'b1;
            end
            else if (cmd.slip_phase)
            begin
                if (cnt_reg[0])
                begin
                    def_vld_reg[32'(dhead_next)*SLIP_OPERATORS + 32'(op_reg)][ch] <= 1'b1;
                    op_reg <= op_reg + 1'b1;
                end
                if (stat.slip_last)
                begin
                    cnt_reg <= '0;
                    dhead_reg[ch] <= dhead_next;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            else if (cmd.mac_phase)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg >= SMP_LEN && cnt_reg < TOT)
                begin
                    if (mcol_reg == OP_W'(SLIP_OPERATORS - 1))
                    begin
                        mcol_reg <= '0;
                        mrow_reg <= mrow_reg + 1'b1;
                    end
                    else
                    begin
                        mcol_reg <= mcol_reg + 1'b1;
                    end
                end
            end
            if (pvld_reg)
            begin
                acc_reg <= acc_reg + pq;
            end
        end
    end

    assign stat.slip_last = cmd.slip_phase
        && (cnt_reg == CNT_W'(2 * SLIP_OPERATORS - 1));
    assign stat.mac_last  = cmd.mac_phase && (cnt_reg == CNT_W'(TOT + 2));

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.out_channel <= cur_reg.channel;
            if (acc_reg > 64'sd2147483647)
            begin
                result_reg.model_output <= 32'sh7fffffff;
                result_reg.saturated    <= 1'b1;
            end
            else if (acc_reg < -64'sd2147483648)
            begin
                result_reg.model_output <= 32'sh80000000;
                result_reg.saturated    <= 1'b1;
            end
            else
            begin
                result_reg.model_output <= acc_reg[31:0];
                result_reg.saturated    <= 1'b0;
            end
        end
    end

    assign result = result_reg;

    `ASSERT_IMPLIES(a_phase, clk, rst_n, 1'b1, !(cmd.slip_phase && cmd.mac_phase))
    `ASSERT_NEXT(a_pipe, clk, rst_n, rvld_reg, pvld_reg)
    `ASSERT_IMPLIES(a_op, clk, rst_n, cmd.slip_phase, cnt_reg < CNT_W'(2 * SLIP_OPERATORS))
endmodule

// ----- rtl/maxwell_slip_friction_model.sv -----
// Top level of the Maxwell-slip friction model.
// Depends on msfm_pkg, msfm_ctrl and msfm_datapath.
//
//  port group   direction  payload
//  in_*         input      msfm_pkg::in_item_t  (load or sample transaction)
//  out_*        output     msfm_pkg::out_item_t (one result per sample)
//
// A coefficient load is written on acceptance and leaves the block idle; a
// sample runs through the slip update and the one shared multiply-accumulate
// walk before its result is registered.
// Reset clears all histories at once through valid bits.
// A finished result waits in the output register while the next transaction
// is accepted; the result stage stalls only when a new result is due.
module maxwell_slip_friction_model #(
    parameter int CHANNELS       = 6,
    parameter int SLIP_OPERATORS = 4,
    parameter int OUTPUT_ORDER   = 3,
    parameter int INPUT_ORDER    = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  msfm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output msfm_pkg::out_item_t out_data
);
    import msfm_pkg::*;

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    out_item_t res;
    logic      idle, busy_done, accept, go, is_sample, out_valid_reg, out_busy;

    assign in_ready  = idle;
    assign accept    = in_valid && in_ready;
    assign is_sample = (in_data.action == ACT_SAMPLE) && (in_data.channel < CHANNELS);
    assign go        = accept && is_sample;
    assign out_busy  = out_valid_reg && !out_ready;

    msfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .out_busy  (out_busy),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (idle),
        .busy_done (busy_done)
    );

    msfm_datapath #(
        .CHANNELS       (CHANNELS),
        .SLIP_OPERATORS (SLIP_OPERATORS),
        .OUTPUT_ORDER   (OUTPUT_ORDER),
        .INPUT_ORDER    (INPUT_ORDER)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_data),
        .item_load (accept && (in_data.channel < CHANNELS)),
        .cmd       (cmd),
        .stat      (stat),
        .result    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (busy_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res;
endmodule
